// ===== rtl/sbeq_pkg.sv =====
`timescale 1ns / 1ps

package sbeq_pkg;

  // Default depth of the error store and the hard ceiling on the overflow limit.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;

  // Depth of the command queue between the decoder and the executor.
  localparam int CMD_QUEUE_DEPTH = 2;

  // Widths fixed by the register set.
  localparam int LIMIT_W = 5;
  localparam int CNT_W   = 5;
  localparam int KIND_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  // Status byte and event status bits.
  localparam logic [7:0] STB_EAV  = 8'h04;
  localparam logic [7:0] STB_MAV  = 8'h10;
  localparam logic [7:0] STB_ESB  = 8'h20;
  localparam logic [7:0] STB_RQS  = 8'h40;
  localparam logic [7:0] RQS_MASK = 8'hBF;
  localparam logic [7:0] ESR_OPC  = 8'h01;

  // Error kinds that the block queues on its own.
  localparam logic [KIND_W-1:0] NUM_KINDS    = 5'd17;
  localparam logic [KIND_W-1:0] ERR_COMMAND  = 5'd1;
  localparam logic [KIND_W-1:0] ERR_NUMERIC  = 5'd6;
  localparam logic [KIND_W-1:0] ERR_OVERFLOW = 5'd14;
  localparam logic [KIND_W-1:0] ERR_QUERY    = 5'd15;

  typedef enum logic [3:0] {
    ACT_OPC      = 4'd0,
    ACT_ESE      = 4'd1,
    ACT_SRE      = 4'd2,
    ACT_CLS      = 4'd3,
    ACT_RST      = 4'd4,
    ACT_IDN      = 4'd5,
    ACT_ESR      = 4'd6,
    ACT_STB      = 4'd7,
    ACT_SELFTEST = 4'd8,
    ACT_POP      = 4'd9,
    ACT_COUNT    = 4'd10,
    ACT_POP_ALL  = 4'd11,
    ACT_REPORT   = 4'd12,
    ACT_SET_BIT  = 4'd13
  } act_e;

  typedef enum logic [1:0] {
    FORM_PLAIN = 2'd0,
    FORM_PARAM = 2'd1,
    FORM_QUERY = 2'd2,
    FORM_BAD   = 2'd3
  } form_e;

  typedef enum logic [2:0] {
    KIND_DONE  = 3'd0,
    KIND_VALUE = 3'd1,
    KIND_ERROR = 3'd2,
    KIND_IDN   = 3'd3,
    KIND_COUNT = 3'd4
  } kind_e;

  // Classified operations handed from the decoder to the executor.
  typedef enum logic [3:0] {
    OP_DONE,
    OP_OPC_SET,
    OP_READ_ONE,
    OP_READ_ESE,
    OP_READ_SRE,
    OP_READ_ESR,
    OP_READ_STB,
    OP_IDN,
    OP_WRITE_ESE,
    OP_WRITE_SRE,
    OP_CLS,
    OP_ADD_ERR,
    OP_POP,
    OP_POP_ALL,
    OP_COUNT,
    OP_SET_BIT
  } op_e;

  // The argument carries the enable value, the error kind or the status bit.
  typedef struct packed {
    op_e        op;
    logic [7:0] arg;
  } cmd_t;

  typedef enum logic {
    BK_EXEC,
    BK_POP
  } bk_state_e;

  typedef struct packed {
    logic [7:0] stb;
    logic       srq;
  } stb_upd_t;

  // Status byte write: a summary hit sets RQS, and raises a request if enabled.
  function automatic stb_upd_t stb_write(logic [7:0] b, logic [7:0] sre);
    stb_upd_t u;
    u.stb = b;
    u.srq = 1'b0;
    if ((b & sre & RQS_MASK) != 8'h00) begin
      u.stb = b | STB_RQS;
      u.srq = sre[6];
    end
    return u;
  endfunction

  function automatic logic signed [9:0] error_code_of(logic [KIND_W-1:0] k);
    logic signed [9:0] c;
    unique case (k)
      5'd1:    c = -10'sd100;
      5'd2:    c = -10'sd103;
      5'd3:    c = -10'sd108;
      5'd4:    c = -10'sd109;
      5'd5:    c = -10'sd113;
      5'd6:    c = -10'sd120;
      5'd7:    c = -10'sd200;
      5'd8:    c = -10'sd203;
      5'd9:    c = -10'sd240;
      5'd10:   c = -10'sd241;
      5'd11:   c = -10'sd257;
      5'd12:   c = -10'sd300;
      5'd13:   c = -10'sd310;
      5'd14:   c = -10'sd350;
      5'd15:   c = -10'sd400;
      5'd16:   c = -10'sd500;
      default: c = 10'sd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/sbeq_ram.sv =====
`timescale 1ns / 1ps

module sbeq_ram #(
  parameter int WIDTH = sbeq_pkg::KIND_W,
  parameter int DEPTH = sbeq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sbeq_front.sv =====
`timescale 1ns / 1ps

module sbeq_front (
  input  logic               start_i,
  input  logic               full_i,
  input  logic [3:0]         action_i,
  input  logic [1:0]         form_i,
  input  logic [7:0]         param_i,
  input  logic               param_ok_i,
  input  logic [4:0]         error_index_i,
  input  logic [2:0]         status_bit_i,
  output logic               push_o,
  output sbeq_pkg::cmd_t     cmd_o
);

  logic is_query;

  assign push_o   = start_i && !full_i;
  assign is_query = (form_i == sbeq_pkg::FORM_QUERY);

  // Classification depends on the command fields only, never on block state.
  always_comb begin
    cmd_o.op  = sbeq_pkg::OP_DONE;
    cmd_o.arg = 8'h00;
    unique case (action_i)
      sbeq_pkg::ACT_OPC: begin
        if (form_i == sbeq_pkg::FORM_PLAIN) begin
          cmd_o.op = sbeq_pkg::OP_OPC_SET;
        end else if (is_query) begin
          cmd_o.op = sbeq_pkg::OP_READ_ONE;
        end else begin
          cmd_o.op  = sbeq_pkg::OP_ADD_ERR;
          cmd_o.arg = 8'(sbeq_pkg::ERR_COMMAND);
        end
      end
      sbeq_pkg::ACT_ESE, sbeq_pkg::ACT_SRE: begin
        if (form_i == sbeq_pkg::FORM_PARAM) begin
          if (!param_ok_i) begin
            cmd_o.op  = sbeq_pkg::OP_ADD_ERR;
            cmd_o.arg = 8'(sbeq_pkg::ERR_NUMERIC);
          end else begin
            cmd_o.op  = (action_i == sbeq_pkg::ACT_ESE) ? sbeq_pkg::OP_WRITE_ESE
                                                        : sbeq_pkg::OP_WRITE_SRE;
            cmd_o.arg = param_i;
          end
        end else if (is_query) begin
          cmd_o.op = (action_i == sbeq_pkg::ACT_ESE) ? sbeq_pkg::OP_READ_ESE
                                                     : sbeq_pkg::OP_READ_SRE;
        end else begin
          cmd_o.op  = sbeq_pkg::OP_ADD_ERR;
          cmd_o.arg = 8'(sbeq_pkg::ERR_COMMAND);
        end
      end
      sbeq_pkg::ACT_CLS, sbeq_pkg::ACT_RST: begin
        if (form_i == sbeq_pkg::FORM_PLAIN) begin
          cmd_o.op = (action_i == sbeq_pkg::ACT_CLS) ? sbeq_pkg::OP_CLS
                                                     : sbeq_pkg::OP_DONE;
        end else if (is_query) begin
          cmd_o.op  = sbeq_pkg::OP_ADD_ERR;
          cmd_o.arg = 8'(sbeq_pkg::ERR_QUERY);
        end else begin
          cmd_o.op  = sbeq_pkg::OP_ADD_ERR;
          cmd_o.arg = 8'(sbeq_pkg::ERR_COMMAND);
        end
      end
      sbeq_pkg::ACT_IDN, sbeq_pkg::ACT_ESR, sbeq_pkg::ACT_STB, sbeq_pkg::ACT_SELFTEST,
      sbeq_pkg::ACT_POP, sbeq_pkg::ACT_COUNT, sbeq_pkg::ACT_POP_ALL: begin
        if (!is_query) begin
          cmd_o.op  = sbeq_pkg::OP_ADD_ERR;
          cmd_o.arg = 8'(sbeq_pkg::ERR_COMMAND);
        end else begin
          unique case (action_i)
            sbeq_pkg::ACT_IDN:      cmd_o.op = sbeq_pkg::OP_IDN;
            sbeq_pkg::ACT_ESR:      cmd_o.op = sbeq_pkg::OP_READ_ESR;
            sbeq_pkg::ACT_STB:      cmd_o.op = sbeq_pkg::OP_READ_STB;
            sbeq_pkg::ACT_SELFTEST: cmd_o.op = sbeq_pkg::OP_READ_ONE;
            sbeq_pkg::ACT_POP:      cmd_o.op = sbeq_pkg::OP_POP;
            sbeq_pkg::ACT_COUNT:    cmd_o.op = sbeq_pkg::OP_COUNT;
            default:                cmd_o.op = sbeq_pkg::OP_POP_ALL;
          endcase
        end
      end
      sbeq_pkg::ACT_REPORT: begin
        // Error kinds at or above NUM_KINDS are dropped.
        if (error_index_i < sbeq_pkg::NUM_KINDS) begin
          cmd_o.op  = sbeq_pkg::OP_ADD_ERR;
          cmd_o.arg = 8'(error_index_i);
        end
      end
      sbeq_pkg::ACT_SET_BIT: begin
        cmd_o.op  = sbeq_pkg::OP_SET_BIT;
        cmd_o.arg = 8'(status_bit_i);
      end
      default: begin
        cmd_o.op = sbeq_pkg::OP_DONE;
      end
    endcase
  end

endmodule

// ===== rtl/sbeq_cmd_queue.sv =====
`timescale 1ns / 1ps

module sbeq_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbeq_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output sbeq_pkg::cmd_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int Depth = sbeq_pkg::CMD_QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  sbeq_pkg::cmd_t entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/sbeq_back.sv =====
`timescale 1ns / 1ps

module sbeq_back #(
  parameter int QUEUE_DEPTH = sbeq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sbeq_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  sbeq_pkg::cmd_t                cmd_i,
  input  logic                          empty_i,
  output logic                          deq_o,
  output logic                          result_valid_o,
  output logic [2:0]                    kind_o,
  output logic [7:0]                    value_o,
  output logic signed [9:0]             error_code_o,
  output logic                          last_o,
  output logic                          service_request_o
);

  localparam int AddrW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int SumW     = AddrW + 6;
  localparam int LimMaxI  = (QUEUE_DEPTH < sbeq_pkg::MAX_RESULTS) ? QUEUE_DEPTH
                                                                  : sbeq_pkg::MAX_RESULTS;
  localparam logic [sbeq_pkg::LIMIT_W-1:0] LimMax = sbeq_pkg::LIMIT_W'(LimMaxI);

  sbeq_pkg::bk_state_e state_q, state_d;

  logic [7:0]                   stb_q, stb_d;
  logic [7:0]                   sre_q, sre_d;
  logic [7:0]                   esr_q, esr_d;
  logic [7:0]                   ese_q, ese_d;
  logic [sbeq_pkg::CNT_W-1:0]   count_q, count_d;
  logic [AddrW-1:0]             head_q, head_d;
  logic [sbeq_pkg::LIMIT_W-1:0] limit_q;
  logic                         pop_all_q, pop_all_d;

  logic                         res_valid_q, res_valid_d;
  logic [2:0]                   kind_q, kind_d;
  logic [7:0]                   value_q, value_d;
  logic signed [9:0]            code_q, code_d;
  logic                         last_q, last_d;
  logic                         srq_q, srq_d;

  logic [sbeq_pkg::LIMIT_W-1:0] limit_eff;
  logic [SumW-1:0]              sum_app, sum_last;
  logic [AddrW-1:0]             slot_app, slot_last, head_inc, raddr;
  logic                         ram_we;
  logic [AddrW-1:0]             ram_waddr;
  logic [sbeq_pkg::KIND_W-1:0]  ram_wdata, ram_rdata;
  logic                         is_pop_op;
  sbeq_pkg::stb_upd_t           upd_pop;

  // Overflow limit clamped into one up to the smaller of the store depth and MAX_RESULTS.
  assign limit_eff = (limit_q == '0) ? sbeq_pkg::LIMIT_W'(1)
                   : (limit_q > LimMax) ? LimMax : limit_q;

  // Slot arithmetic: head plus count stays below twice the depth.
  assign sum_app   = SumW'(head_q) + SumW'(count_q);
  assign sum_last  = sum_app - SumW'(1);
  assign slot_app  = (sum_app >= SumW'(QUEUE_DEPTH)) ? AddrW'(sum_app - SumW'(QUEUE_DEPTH))
                                                     : AddrW'(sum_app);
  assign slot_last = (sum_last >= SumW'(QUEUE_DEPTH)) ? AddrW'(sum_last - SumW'(QUEUE_DEPTH))
                                                      : AddrW'(sum_last);
  assign head_inc  = (head_q == AddrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

  // While popping, the read for the following entry is issued ahead.
  assign raddr     = (state_q == sbeq_pkg::BK_POP) ? head_inc : head_q;
  assign is_pop_op = (cmd_i.op == sbeq_pkg::OP_POP) || (cmd_i.op == sbeq_pkg::OP_POP_ALL);

  // The status byte does not change during a pop-all until its final entry.
  assign upd_pop = sbeq_pkg::stb_write(stb_q & ~sbeq_pkg::STB_EAV, sre_q);

  sbeq_ram #(
    .WIDTH (sbeq_pkg::KIND_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbeq_pkg::BK_EXEC: begin
        if (!empty_i && is_pop_op && (count_q != '0)) begin
          state_d = sbeq_pkg::BK_POP;
        end
      end
      sbeq_pkg::BK_POP: begin
        if (!pop_all_q || (count_q == sbeq_pkg::CNT_W'(1))) begin
          state_d = sbeq_pkg::BK_EXEC;
        end
      end
      default: begin
        state_d = sbeq_pkg::BK_EXEC;
      end
    endcase
  end

  always_comb begin
    sbeq_pkg::stb_upd_t upd;
    logic [7:0]         esr_new;
    upd         = '0;
    esr_new     = esr_q | sbeq_pkg::ESR_OPC;
    stb_d       = stb_q;
    sre_d       = sre_q;
    esr_d       = esr_q;
    ese_d       = ese_q;
    count_d     = count_q;
    head_d      = head_q;
    pop_all_d   = pop_all_q;
    deq_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = slot_app;
    ram_wdata   = cmd_i.arg[sbeq_pkg::KIND_W-1:0];
    res_valid_d = 1'b0;
    kind_d      = sbeq_pkg::KIND_DONE;
    value_d     = 8'h00;
    code_d      = 10'sd0;
    last_d      = 1'b1;
    srq_d       = 1'b0;
    unique case (state_q)
      sbeq_pkg::BK_EXEC: begin
        if (!empty_i) begin
          deq_o       = 1'b1;
          res_valid_d = 1'b1;
          unique case (cmd_i.op)
            sbeq_pkg::OP_OPC_SET: begin
              esr_d = esr_new;
              if ((esr_new & ese_q) != 8'h00) begin
                upd   = sbeq_pkg::stb_write(stb_q | sbeq_pkg::STB_ESB, sre_q);
                stb_d = upd.stb;
                srq_d = upd.srq;
              end
            end
            sbeq_pkg::OP_WRITE_ESE: begin
              ese_d = cmd_i.arg;
              if ((esr_q & cmd_i.arg) != 8'h00) begin
                upd   = sbeq_pkg::stb_write(stb_q | sbeq_pkg::STB_ESB, sre_q);
                stb_d = upd.stb;
                srq_d = upd.srq;
              end
            end
            sbeq_pkg::OP_WRITE_SRE: begin
              sre_d = cmd_i.arg;
              upd   = sbeq_pkg::stb_write(stb_q, cmd_i.arg);
              stb_d = upd.stb;
              srq_d = upd.srq;
            end
            sbeq_pkg::OP_CLS: begin
              // Clearing leaves nothing that could match an enable.
              esr_d   = 8'h00;
              stb_d   = 8'h00;
              count_d = '0;
              head_d  = '0;
            end
            sbeq_pkg::OP_ADD_ERR: begin
              upd    = sbeq_pkg::stb_write(stb_q | sbeq_pkg::STB_EAV, sre_q);
              stb_d  = upd.stb;
              srq_d  = upd.srq;
              ram_we = 1'b1;
              if (count_q >= limit_eff) begin
                // A full queue has its newest entry replaced by overflow.
                ram_waddr = slot_last;
                ram_wdata = sbeq_pkg::ERR_OVERFLOW;
              end else begin
                count_d = count_q + 1'b1;
              end
            end
            sbeq_pkg::OP_SET_BIT: begin
              upd   = sbeq_pkg::stb_write(stb_q | (8'h01 << cmd_i.arg[2:0]), sre_q);
              stb_d = upd.stb;
              srq_d = upd.srq;
            end
            sbeq_pkg::OP_READ_ONE: begin
              kind_d  = sbeq_pkg::KIND_VALUE;
              value_d = 8'h01;
            end
            sbeq_pkg::OP_READ_ESE: begin
              kind_d  = sbeq_pkg::KIND_VALUE;
              value_d = ese_q;
            end
            sbeq_pkg::OP_READ_SRE: begin
              kind_d  = sbeq_pkg::KIND_VALUE;
              value_d = sre_q;
            end
            sbeq_pkg::OP_READ_ESR: begin
              kind_d  = sbeq_pkg::KIND_VALUE;
              value_d = esr_q;
            end
            sbeq_pkg::OP_READ_STB: begin
              kind_d  = sbeq_pkg::KIND_VALUE;
              value_d = stb_q;
            end
            sbeq_pkg::OP_IDN: begin
              kind_d = sbeq_pkg::KIND_IDN;
            end
            sbeq_pkg::OP_COUNT: begin
              kind_d  = sbeq_pkg::KIND_COUNT;
              value_d = 8'(count_q);
            end
            sbeq_pkg::OP_POP, sbeq_pkg::OP_POP_ALL: begin
              kind_d = sbeq_pkg::KIND_ERROR;
              if (count_q != '0) begin
                // The store read is under way; results follow from the pop state.
                res_valid_d = 1'b0;
                pop_all_d   = (cmd_i.op == sbeq_pkg::OP_POP_ALL);
              end
            end
            default: begin
              kind_d = sbeq_pkg::KIND_DONE;
            end
          endcase
        end
      end
      sbeq_pkg::BK_POP: begin
        res_valid_d = 1'b1;
        kind_d      = sbeq_pkg::KIND_ERROR;
        code_d      = sbeq_pkg::error_code_of(ram_rdata);
        last_d      = !pop_all_q || (count_q == sbeq_pkg::CNT_W'(1));
        srq_d       = upd_pop.srq && (pop_all_q || (count_q == sbeq_pkg::CNT_W'(1)));
        head_d      = head_inc;
        count_d     = count_q - 1'b1;
        if (count_q == sbeq_pkg::CNT_W'(1)) begin
          stb_d = upd_pop.stb;
        end
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbeq_pkg::BK_EXEC;
      stb_q       <= 8'h00;
      sre_q       <= 8'h00;
      esr_q       <= 8'h00;
      ese_q       <= 8'h00;
      count_q     <= '0;
      head_q      <= '0;
      limit_q     <= sbeq_pkg::LIMIT_RESET;
      pop_all_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stb_q       <= stb_d;
      sre_q       <= sre_d;
      esr_q       <= esr_d;
      ese_q       <= ese_d;
      count_q     <= count_d;
      head_q      <= head_d;
      pop_all_q   <= pop_all_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    code_q  <= code_d;
    last_q  <= last_d;
    srq_q   <= srq_d;
  end

  assign result_valid_o    = res_valid_q;
  assign kind_o            = kind_q;
  assign value_o           = value_q;
  assign error_code_o      = code_q;
  assign last_o            = last_q;
  assign service_request_o = srq_q;

endmodule

// ===== rtl/status_byte_error_queue_core.sv =====
`timescale 1ns / 1ps

// Status reporting core: status byte, service request enable, event status
// register and its enable, plus a queue of error kinds.
// Command channel: a transaction is taken at a rising edge with start_i high
// and busy_o low. The fields are decoded at once and the classified command
// goes into a two-entry queue; busy_o is high while that queue is full.
// Result channel: each result is shown for exactly one cycle with
// result_valid_o high, and last_o marks the final result of a command.
// The receiver cannot stall this channel, so no back-pressure exists there.
// Flow: a command waits in the command queue until the executor takes it,
// and the executor registers its result onto the ports. An error pop also
// waits on the registered read of the error store; a pop-all then gives one
// entry per cycle. The executor handles one command at a time; single-result
// commands sustain one per cycle while no pop is under way.
// Configuration: cfg_we_i writes the overflow limit; the user must write it
// only while idle, since the block itself does not enforce this.
// Reset clears the status and enable registers, the result valid flag, the
// error count and the queues and sets the limit to sixteen. The error store
// itself needs no clearing pass because an entry is always written before it
// is read.
module status_byte_error_queue_core #(
  parameter int QUEUE_DEPTH = sbeq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cfg_we_i,
  input  logic [sbeq_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic [3:0]                   action_i,
  input  logic [1:0]                   form_i,
  input  logic [7:0]                   param_i,
  input  logic                         param_ok_i,
  input  logic [4:0]                   error_index_i,
  input  logic [2:0]                   status_bit_i,
  output logic                         result_valid_o,
  output logic [2:0]                   kind_o,
  output logic [7:0]                   value_o,
  output logic signed [9:0]            error_code_o,
  output logic                         last_o,
  output logic                         service_request_o
);

  logic           push;
  sbeq_pkg::cmd_t cmd_in;
  sbeq_pkg::cmd_t cmd_head;
  logic           q_empty;
  logic           q_full;
  logic           deq;

  // The front end only decodes; it never looks at the status registers.
  sbeq_front u_front (
    .start_i       (start_i),
    .full_i        (q_full),
    .action_i      (action_i),
    .form_i        (form_i),
    .param_i       (param_i),
    .param_ok_i    (param_ok_i),
    .error_index_i (error_index_i),
    .status_bit_i  (status_bit_i),
    .push_o        (push),
    .cmd_o         (cmd_in)
  );

  sbeq_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .pop_i   (deq),
    .head_o  (cmd_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // The back end owns all status state and the error store.
  sbeq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd_head),
    .empty_i           (q_empty),
    .deq_o             (deq),
    .result_valid_o    (result_valid_o),
    .kind_o            (kind_o),
    .value_o           (value_o),
    .error_code_o      (error_code_o),
    .last_o            (last_o),
    .service_request_o (service_request_o)
  );

  assign busy_o = q_full;

`ifndef SYNTHESIS
  // A full command queue always has something for the executor.
  a_busy_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !q_empty)
    else $error("busy while the command queue is empty");

  // Only error entries carry a nonzero error code.
  a_code_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (error_code_o != 10'sd0)) |-> (kind_o == sbeq_pkg::KIND_ERROR))
    else $error("error code on a result that is not an error entry");

  // The queue can only fill up through a taken command.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a command transaction");
`endif

endmodule
